// ----- rtl/pddl_pkg.sv -----
// Shared constants, token codes, scanner modes and keyword tables for the PDDL token scanner.
package pddl_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned LINE_BITS_DEF   = 24;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned MAX_TOKENS      = 3;
  localparam int unsigned KW_COUNT        = 36;
  localparam int unsigned SYM_COUNT       = 44;
  localparam int unsigned KW_MAX_CHARS    = 25;

  localparam logic [6:0] K_LPAREN   = 7'd0;
  localparam logic [6:0] K_RPAREN   = 7'd1;
  localparam logic [6:0] K_PLUS     = 7'd2;
  localparam logic [6:0] K_MINUS    = 7'd3;
  localparam logic [6:0] K_STAR     = 7'd4;
  localparam logic [6:0] K_SLASH    = 7'd5;
  localparam logic [6:0] K_EQ       = 7'd6;
  localparam logic [6:0] K_LT       = 7'd7;
  localparam logic [6:0] K_LE       = 7'd8;
  localparam logic [6:0] K_GT       = 7'd9;
  localparam logic [6:0] K_GE       = 7'd10;
  localparam logic [6:0] K_TRUE     = 7'd11;
  localparam logic [6:0] K_NUMBER   = 7'd12;
  localparam logic [6:0] K_NAME     = 7'd13;
  localparam logic [6:0] K_VARIABLE = 7'd14;
  localparam logic [6:0] K_KW_BASE  = 7'd15;
  localparam logic [6:0] K_SYM_BASE = 7'd51;
  localparam logic [6:0] K_EOF      = 7'd95;
  localparam logic [6:0] K_ERROR    = 7'd96;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_BAD_CHAR = 2'd1;
  localparam logic [1:0] E_BAD_SYM  = 2'd2;
  localparam logic [1:0] E_BAD_VAR  = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_QUES  = "?";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_LPAR  = "(";
  localparam logic [7:0] CH_RPAR  = ")";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_T     = "t";

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_COMMENT = 4'd1,
    M_INT     = 4'd2,
    M_DOT     = 4'd3,
    M_FRAC    = 4'd4,
    M_NAME    = 4'd5,
    M_SYM     = 4'd6,
    M_VAR1    = 4'd7,
    M_VAR     = 4'd8,
    M_LTS     = 4'd9,
    M_GTS     = 4'd10,
    M_HASH    = 4'd11
  } mode_t;

  localparam logic [199:0] KW_STR [KW_COUNT] = '{
    "all", "always", "always-within", "and", "assign", "decrease", "at",
    "at-most-once", "define", "domain", "either", "end", "exists", "forall",
    "hold-after", "hold-during", "imply", "increase", "is-violated",
    "maximize", "minimize", "not", "object", "or", "over", "preference",
    "problem", "scale-up", "start", "sometime", "sometime-after",
    "sometime-before", "total-time", "undefined", "when", "within"
  };

  localparam logic [199:0] SYM_STR [SYM_COUNT] = '{
    "action", "action-costs", "adl", "condition", "conditional-effects",
    "constants", "constraints", "continuous-effects", "derived",
    "derived-predicates", "disjunctive-preconditions", "domain",
    "domain-axioms", "duration", "duration-inequalities", "durative-action",
    "durative-actions", "effect", "equality", "existential-preconditions",
    "fluents", "functions", "goal", "goal-utilities", "init", "length",
    "metric", "negative-preconditions", "numeric-fluents", "objects",
    "parallel", "parameters", "precondition", "predicates", "preferences",
    "quantified-preconditions", "requirements", "serial", "strips",
    "timed-initial-literals", "types", "typing", "universal-preconditions",
    "vars"
  };

  function automatic logic [4:0] str_len(input logic [199:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int k = 0; k < 25; k++) begin
      if (v[8*k +: 8] != 8'd0) n = n + 5'd1;
    end
    return n;
  endfunction

  function automatic logic str_hit(input logic [199:0] v, input logic [4:0] p,
                                   input logic [7:0] b);
    logic [4:0] ln;
    logic h;
    ln = str_len(v);
    h = 1'b0;
    if (p < ln) h = (v[8*(ln - 5'd1 - p) +: 8] == b);
    return h;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || is_letter(c) || (c == CH_MINUS) || (c == CH_UNDER);
  endfunction

endpackage

// ----- rtl/pddl_token_scanner.sv -----
// Top level of the PDDL token scanner: front end, bundle queue and output back end.
// Path: a token built from an accepted byte is written into the bundle queue and then loaded into the output register.
// Throughput: one byte per cycle while the 4-bundle queue has room; one token word
// leaves per cycle while token_stall is low.
// Reset: mode idle, line and column 1, length 0, queue and output register empty.
module pddl_token_scanner #(
  parameter int unsigned LENGTH_BITS = pddl_pkg::LENGTH_BITS_DEF,
  parameter int unsigned LINE_BITS   = pddl_pkg::LINE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   source_valid,
  output logic                   source_stall,
  input  logic [7:0]             source_byte,
  output logic                   token_valid,
  input  logic                   token_stall,
  output logic [6:0]             token_kind,
  output logic [1:0]             error_code,
  output logic [LENGTH_BITS-1:0] token_size,
  output logic [LINE_BITS-1:0]   line_number,
  output logic [15:0]            column_number,
  output logic                   last_of_run
);
  localparam int unsigned TOK_BITS    = 7 + 2 + LENGTH_BITS + LINE_BITS + 16;
  localparam int unsigned BUNDLE_BITS = 2 + pddl_pkg::MAX_TOKENS * TOK_BITS;

  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   empty;
  logic [BUNDLE_BITS-1:0] wdata;
  logic [BUNDLE_BITS-1:0] rdata;

  pddl_front #(
    .LENGTH_BITS (LENGTH_BITS),
    .LINE_BITS   (LINE_BITS),
    .BUNDLE_BITS (BUNDLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .source_valid (source_valid),
    .source_byte  (source_byte),
    .full         (full),
    .source_stall (source_stall),
    .push         (push),
    .bundle       (wdata)
  );

  pddl_fifo #(
    .WIDTH (BUNDLE_BITS),
    .DEPTH (pddl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .rdata (rdata),
    .full  (full),
    .empty (empty)
  );

  pddl_back #(
    .LENGTH_BITS (LENGTH_BITS),
    .LINE_BITS   (LINE_BITS),
    .BUNDLE_BITS (BUNDLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .rdata         (rdata),
    .pop           (pop),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .token_kind    (token_kind),
    .error_code    (error_code),
    .token_size    (token_size),
    .line_number   (line_number),
    .column_number (column_number),
    .last_of_run   (last_of_run)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("bundle pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("bundle popped from empty queue");
  a_err_only_on_error: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_kind != pddl_pkg::K_ERROR) |-> (error_code == pddl_pkg::E_NONE))
    else $error("error code on a non-error token");
  a_eof_zero_len: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_kind == pddl_pkg::K_EOF) |-> (token_size == '0 && last_of_run))
    else $error("end of source token malformed");
`endif
endmodule

// ----- rtl/pddl_fifo.sv -----
// Small register queue of token bundles between the scanner front and the output back end.
module pddl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = pddl_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule

// ----- rtl/pddl_front.sv -----
// Scanner front end: one byte per cycle unless the queue is full; tracks position and keyword matches, builds bundles.
module pddl_front #(
  parameter int unsigned LENGTH_BITS = pddl_pkg::LENGTH_BITS_DEF,
  parameter int unsigned LINE_BITS   = pddl_pkg::LINE_BITS_DEF,
  parameter int unsigned BUNDLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   source_valid,
  input  logic [7:0]             source_byte,
  input  logic                   full,
  output logic                   source_stall,
  output logic                   push,
  output logic [BUNDLE_BITS-1:0] bundle
);
  typedef struct packed {
    logic [6:0]             kind;
    logic [1:0]             err;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [15:0]            col;
  } tok_t;

  typedef struct packed {
    logic [1:0]       cnt;
    tok_t [2:0]       tok;
  } bundle_t;

  localparam int unsigned KWN  = pddl_pkg::KW_COUNT;
  localparam int unsigned SYMN = pddl_pkg::SYM_COUNT;

  pddl_pkg::mode_t        mode, mode_next;
  logic [LENGTH_BITS-1:0] len, len_next;
  logic [LINE_BITS-1:0]   line, line_next;
  logic [15:0]            col, col_next;
  logic [15:0]            scol, scol_next;
  logic                   flag, flag_next;
  logic [KWN-1:0]         kwm, kwm_next;
  logic [SYMN-1:0]        symm, symm_next;

  bundle_t                bnd;
  logic [1:0]             n;
  logic                   again;
  logic [LENGTH_BITS-1:0] pos;
  logic                   pos_ok;
  logic [6:0]             kk;
  logic [7:0]             b;
  logic                   accept;

  assign b            = source_byte;
  assign source_stall = full;
  assign accept       = source_valid && !full;
  assign push         = accept && (n != 2'd0);
  assign bundle       = BUNDLE_BITS'(bnd);

  function automatic logic [15:0] cinc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] linc(input logic [LENGTH_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  always_comb begin
    mode_next = mode;
    len_next  = len;
    line_next = line;
    col_next  = col;
    scol_next = scol;
    flag_next = flag;
    kwm_next  = kwm;
    symm_next = symm;
    bnd       = '0;
    n         = 2'd0;
    again     = 1'b0;
    pos       = '0;
    pos_ok    = 1'b0;
    kk        = pddl_pkg::K_NAME;

    case (mode)
      pddl_pkg::M_COMMENT: begin
        if (b == pddl_pkg::CH_NUL || b == pddl_pkg::CH_LF) again = 1'b1;
        else col_next = cinc(col_next);
      end
      pddl_pkg::M_INT, pddl_pkg::M_FRAC: begin
        if (pddl_pkg::is_digit(b)) begin
          len_next = linc(len_next);
          col_next = cinc(col_next);
        end else if (mode == pddl_pkg::M_INT && b == pddl_pkg::CH_DOT) begin
          mode_next = pddl_pkg::M_DOT;
        end else begin
          bnd.tok[n] = '{pddl_pkg::K_NUMBER, pddl_pkg::E_NONE, len_next, line_next, scol_next};
          n = n + 2'd1;
          again = 1'b1;
        end
      end
      pddl_pkg::M_DOT: begin
        if (pddl_pkg::is_digit(b)) begin
          len_next  = linc(linc(len_next));
          col_next  = cinc(cinc(col_next));
          mode_next = pddl_pkg::M_FRAC;
        end else begin
          bnd.tok[n] = '{pddl_pkg::K_NUMBER, pddl_pkg::E_NONE, len_next, line_next, scol_next};
          n = n + 2'd1;
          scol_next = col_next;
          len_next  = LENGTH_BITS'(1);
          col_next  = cinc(col_next);
          bnd.tok[n] = '{pddl_pkg::K_ERROR, pddl_pkg::E_BAD_CHAR, len_next, line_next,
                         scol_next};
          n = n + 2'd1;
          again = 1'b1;
        end
      end
      pddl_pkg::M_NAME: begin
        if (pddl_pkg::is_word(b)) begin
          len_next = linc(len_next);
          col_next = cinc(col_next);
          pos      = len_next - LENGTH_BITS'(1);
          pos_ok   = pos < LENGTH_BITS'(pddl_pkg::KW_MAX_CHARS);
          for (int i = 0; i < KWN; i++) begin
            kwm_next[i] = kwm[i] && pos_ok &&
                          pddl_pkg::str_hit(pddl_pkg::KW_STR[i], pos[4:0], b);
          end
        end else begin
          for (int i = 0; i < KWN; i++) begin
            if (kwm[i] && len == LENGTH_BITS'(pddl_pkg::str_len(pddl_pkg::KW_STR[i])))
              kk = pddl_pkg::K_KW_BASE + 7'(i);
          end
          bnd.tok[n] = '{kk, pddl_pkg::E_NONE, len_next, line_next, scol_next};
          n = n + 2'd1;
          again = 1'b1;
        end
      end
      pddl_pkg::M_SYM: begin
        if (pddl_pkg::is_word(b)) begin
          len_next = linc(len_next);
          col_next = cinc(col_next);
          pos      = len_next - LENGTH_BITS'(2);
          pos_ok   = pos < LENGTH_BITS'(pddl_pkg::KW_MAX_CHARS);
          for (int i = 0; i < SYMN; i++) begin
            symm_next[i] = symm[i] && pos_ok &&
                           pddl_pkg::str_hit(pddl_pkg::SYM_STR[i], pos[4:0], b);
          end
        end else begin
          kk = pddl_pkg::K_ERROR;
          for (int i = 0; i < SYMN; i++) begin
            if (symm[i] && (len - LENGTH_BITS'(1)) ==
                LENGTH_BITS'(pddl_pkg::str_len(pddl_pkg::SYM_STR[i])))
              kk = pddl_pkg::K_SYM_BASE + 7'(i);
          end
          bnd.tok[n] = '{kk, (kk == pddl_pkg::K_ERROR) ? pddl_pkg::E_BAD_SYM : pddl_pkg::E_NONE,
                         len_next, line_next, scol_next};
          n = n + 2'd1;
          again = 1'b1;
        end
      end
      pddl_pkg::M_VAR1: begin
        if (b == pddl_pkg::CH_NUL) begin
          bnd.tok[n] = '{pddl_pkg::K_ERROR, pddl_pkg::E_BAD_VAR, len_next, line_next,
                         scol_next};
          n = n + 2'd1;
          again = 1'b1;
        end else begin
          flag_next = !pddl_pkg::is_letter(b);
          len_next  = linc(len_next);
          col_next  = cinc(col_next);
          mode_next = pddl_pkg::M_VAR;
        end
      end
      pddl_pkg::M_VAR: begin
        if (pddl_pkg::is_word(b)) begin
          len_next = linc(len_next);
          col_next = cinc(col_next);
        end else begin
          bnd.tok[n] = '{flag ? pddl_pkg::K_ERROR : pddl_pkg::K_VARIABLE,
                         flag ? pddl_pkg::E_BAD_VAR : pddl_pkg::E_NONE,
                         len_next, line_next, scol_next};
          n = n + 2'd1;
          flag_next = 1'b0;
          again = 1'b1;
        end
      end
      pddl_pkg::M_LTS, pddl_pkg::M_GTS: begin
        if (b == pddl_pkg::CH_EQ) begin
          len_next  = linc(len_next);
          col_next  = cinc(col_next);
          bnd.tok[n] = '{(mode == pddl_pkg::M_LTS) ? pddl_pkg::K_LE : pddl_pkg::K_GE,
                         pddl_pkg::E_NONE, len_next, line_next, scol_next};
          n = n + 2'd1;
          mode_next = pddl_pkg::M_IDLE;
        end else begin
          bnd.tok[n] = '{(mode == pddl_pkg::M_LTS) ? pddl_pkg::K_LT : pddl_pkg::K_GT,
                         pddl_pkg::E_NONE, len_next, line_next, scol_next};
          n = n + 2'd1;
          again = 1'b1;
        end
      end
      pddl_pkg::M_HASH: begin
        if (b == pddl_pkg::CH_T) begin
          len_next  = linc(len_next);
          col_next  = cinc(col_next);
          bnd.tok[n] = '{pddl_pkg::K_TRUE, pddl_pkg::E_NONE, len_next, line_next, scol_next};
          n = n + 2'd1;
          mode_next = pddl_pkg::M_IDLE;
        end else begin
          bnd.tok[n] = '{pddl_pkg::K_ERROR, pddl_pkg::E_BAD_CHAR, len_next, line_next,
                         scol_next};
          n = n + 2'd1;
          again = 1'b1;
        end
      end
      default: again = 1'b1;
    endcase

    if (again) begin
      mode_next = pddl_pkg::M_IDLE;
      if (b == pddl_pkg::CH_NUL) begin
        bnd.tok[n] = '{pddl_pkg::K_EOF, pddl_pkg::E_NONE, '0, line_next, col_next};
        n = n + 2'd1;
        line_next = LINE_BITS'(1);
        col_next  = 16'd1;
      end else if (b == pddl_pkg::CH_SPACE || b == pddl_pkg::CH_TAB ||
                   b == pddl_pkg::CH_CR) begin
        col_next = cinc(col_next);
      end else if (b == pddl_pkg::CH_LF) begin
        if (line_next != '1) line_next = line_next + 1'b1;
        col_next = 16'd1;
      end else if (b == pddl_pkg::CH_SEMI) begin
        col_next  = cinc(col_next);
        mode_next = pddl_pkg::M_COMMENT;
      end else begin
        scol_next = col_next;
        len_next  = LENGTH_BITS'(1);
        col_next  = cinc(col_next);
        flag_next = 1'b0;
        if (pddl_pkg::is_digit(b)) begin
          mode_next = pddl_pkg::M_INT;
        end else if (pddl_pkg::is_letter(b)) begin
          for (int i = 0; i < KWN; i++)
            kwm_next[i] = pddl_pkg::str_hit(pddl_pkg::KW_STR[i], 5'd0, b);
          mode_next = pddl_pkg::M_NAME;
        end else if (b == pddl_pkg::CH_COLON) begin
          symm_next = '1;
          mode_next = pddl_pkg::M_SYM;
        end else if (b == pddl_pkg::CH_QUES) begin
          mode_next = pddl_pkg::M_VAR1;
        end else if (b == pddl_pkg::CH_LT) begin
          mode_next = pddl_pkg::M_LTS;
        end else if (b == pddl_pkg::CH_GT) begin
          mode_next = pddl_pkg::M_GTS;
        end else if (b == pddl_pkg::CH_HASH) begin
          mode_next = pddl_pkg::M_HASH;
        end else begin
          case (b)
            pddl_pkg::CH_LPAR:  kk = pddl_pkg::K_LPAREN;
            pddl_pkg::CH_RPAR:  kk = pddl_pkg::K_RPAREN;
            pddl_pkg::CH_PLUS:  kk = pddl_pkg::K_PLUS;
            pddl_pkg::CH_MINUS: kk = pddl_pkg::K_MINUS;
            pddl_pkg::CH_STAR:  kk = pddl_pkg::K_STAR;
            pddl_pkg::CH_SLASH: kk = pddl_pkg::K_SLASH;
            pddl_pkg::CH_EQ:    kk = pddl_pkg::K_EQ;
            default:            kk = pddl_pkg::K_ERROR;
          endcase
          bnd.tok[n] = '{kk, (kk == pddl_pkg::K_ERROR) ? pddl_pkg::E_BAD_CHAR : pddl_pkg::E_NONE,
                         len_next, line_next, scol_next};
          n = n + 2'd1;
        end
      end
    end
    bnd.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= pddl_pkg::M_IDLE;
      len  <= '0;
      line <= LINE_BITS'(1);
      col  <= 16'd1;
      scol <= '0;
      flag <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      len  <= len_next;
      line <= line_next;
      col  <= col_next;
      scol <= scol_next;
      flag <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kwm  <= kwm_next;
      symm <= symm_next;
    end
  end
endmodule

// ----- rtl/pddl_back.sv -----
// Output back end: pops token bundles from the queue and hands out one token word per cycle while token_stall is low.
module pddl_back #(
  parameter int unsigned LENGTH_BITS = pddl_pkg::LENGTH_BITS_DEF,
  parameter int unsigned LINE_BITS   = pddl_pkg::LINE_BITS_DEF,
  parameter int unsigned BUNDLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   empty,
  input  logic [BUNDLE_BITS-1:0] rdata,
  output logic                   pop,
  output logic                   token_valid,
  input  logic                   token_stall,
  output logic [6:0]             token_kind,
  output logic [1:0]             error_code,
  output logic [LENGTH_BITS-1:0] token_size,
  output logic [LINE_BITS-1:0]   line_number,
  output logic [15:0]            column_number,
  output logic                   last_of_run
);
  typedef struct packed {
    logic [6:0]             kind;
    logic [1:0]             err;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [15:0]            col;
  } tok_t;

  typedef struct packed {
    logic [1:0]       cnt;
    tok_t [2:0]       tok;
  } bundle_t;

  bundle_t    cur;
  logic [1:0] idx;
  logic       hv;
  logic       take;
  logic       last;
  tok_t       t;

  assign last  = (idx == cur.cnt - 2'd1);
  assign take  = hv && !token_stall;
  assign pop   = !empty && (!hv || (take && last));
  assign t     = cur.tok[idx];

  assign token_valid   = hv;
  assign token_kind    = t.kind;
  assign error_code    = t.err;
  assign token_size    = t.len;
  assign line_number   = t.line;
  assign column_number = t.col;
  assign last_of_run   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      hv  <= 1'b0;
      idx <= 2'd0;
    end else if (pop) begin
      hv  <= 1'b1;
      idx <= 2'd0;
    end else if (take) begin
      if (last) hv <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= bundle_t'(rdata);
  end
endmodule
